[design/pawd_pkg.sv]
// Shared types, constants and fixed-point helpers for the PID controller.
package pawd_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [31:0] US_PER_SEC = 32'd1000000;
    // ceil(2^83 / 10^6); exact quotient by 10^6 for any dividend below 2^63
    localparam logic [63:0] US_RECIP = 64'd9671406556917033398;
    localparam int US_RECIP_SHIFT = 19;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_DRIVE_MIN = 3'd3;
    localparam logic [2:0] REG_DRIVE_MAX = 3'd4;
    localparam logic [2:0] REG_ITERM_LIM = 3'd5;
    localparam logic [2:0] REG_ALPHA     = 3'd6;

    typedef struct packed {
        logic signed [31:0] error_in;
        logic [31:0]        time_us;
    } pawd_in_t;

    typedef struct packed {
        logic signed [31:0] drive_out;
        logic               iterm_clamped;
        logic               drive_clamped;
    } pawd_out_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } pawd_div_req_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        abs32 = x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic [31:0] abs33(input logic signed [32:0] x);
        logic signed [32:0] n;
        n = -x;
        abs33 = x[32] ? n[31:0] : x[31:0];
    endfunction

    function automatic logic [47:0] abs48(input logic signed [47:0] x);
        abs48 = x[47] ? 48'(-x) : 48'(x);
    endfunction

    // apply sign to a magnitude and saturate to 32 bits
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic signed [31:0] r;
        if (neg)
            r = (mag >= 64'h8000_0000) ? S32_MIN : -$signed(mag[31:0]);
        else
            r = (mag > 64'h7FFF_FFFF) ? S32_MAX : $signed(mag[31:0]);
        sat_mag = r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(S32_MAX))
            r = S32_MAX;
        else if (v < 64'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        sat32 = r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v > 49'(S48_MAX))
            r = S48_MAX;
        else if (v < 49'(S48_MIN))
            r = S48_MIN;
        else
            r = v[47:0];
        sat48 = r;
    endfunction

endpackage

[design/pid_antiwindup_filtered_deriv.sv]
// PID controller, Q16.16, integral anti-windup and filtered derivative.
// A single multiplier and divider are reused, so in_ready stays low while an item is in
// work, and a result stall also holds back the next item.
// Reset: asynchronous, active low; registers to defaults, state cleared, first step set.
module pid_antiwindup_filtered_deriv (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pawd_pkg::pawd_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pawd_pkg::pawd_out_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import pawd_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE = 22'h000001,
        S_P1   = 22'h000002,
        S_P2   = 22'h000004,
        S_I1   = 22'h000008,
        S_I2   = 22'h000010,
        S_I3   = 22'h000020,
        S_IR1  = 22'h000040,
        S_IR2  = 22'h000080,
        S_IR3  = 22'h000100,
        S_I4   = 22'h000200,
        S_I5   = 22'h000400,
        S_I6   = 22'h000800,
        S_I7   = 22'h001000,
        S_I8   = 22'h002000,
        S_D1   = 22'h004000,
        S_D2   = 22'h008000,
        S_D3   = 22'h010000,
        S_D4   = 22'h020000,
        S_D5   = 22'h040000,
        S_D6   = 22'h080000,
        S_D7   = 22'h100000,
        S_FIN  = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg, dmin_reg, dmax_reg;
    logic [30:0]        ilim_reg;
    logic [16:0]        alpha_reg;

    logic signed [47:0] acc_reg, acc_next;
    logic signed [31:0] last_err_reg, df_reg, df_next;
    logic [31:0]        last_time_reg;
    logic               first_reg;

    logic signed [31:0] err_reg;
    logic [31:0]        d_reg;
    logic signed [31:0] drive_reg, drive_next;
    logic signed [31:0] iterm_reg, iterm_next;
    logic signed [31:0] raw_reg, raw_next;
    logic [63:0]        ph_reg, ph_next;
    logic [65:0]        rcp_reg, rcp_next;
    logic               iclamp_reg, iclamp_next;
    logic               div_neg_reg, div_neg_next;

    logic               out_valid_reg;
    pawd_out_t          out_reg;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod;
    pawd_div_req_t      div_req;
    logic [63:0]        quo;
    logic               div_done;

    logic               timed;
    logic signed [63:0] quo_s;
    logic signed [32:0] err_diff, e_diff;
    logic [47:0]        acc_mag;
    logic [63:0]        wide_mag;
    logic signed [31:0] wide_term;
    logic signed [31:0] lim_s;
    logic [63:0]        step_mag;
    logic signed [63:0] step_s;
    logic [63:0]        rcp_sum;
    logic [47:0]        inc_mag;
    logic signed [48:0] inc_s;
    logic               goto_i, goto_d;
    logic signed [31:0] drive_fin;
    logic               dclamp;

    pawd_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pawd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .quotient (quo),
        .done     (div_done)
    );

    assign timed    = (d_reg != 32'd0);
    assign quo_s    = div_neg_reg ? -$signed(quo) : $signed(quo);
    assign err_diff = 33'(err_reg) - 33'(last_err_reg);
    assign e_diff   = 33'(raw_reg) - 33'(df_reg);
    assign acc_mag  = abs48(acc_reg);
    assign lim_s    = $signed({1'b0, ilim_reg});
    assign goto_i   = (gain_i_reg != 32'sd0) && timed;
    assign goto_d   = (gain_d_reg != 32'sd0) && timed;

    // |error| * dt / 10^6 by reciprocal: four partial products, low end folded first
    assign rcp_sum  = 64'(rcp_reg >> 32) + prod;
    assign inc_mag  = 48'(rcp_sum >> US_RECIP_SHIFT);
    assign inc_s    = err_reg[31] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});

    // gain_i * acc >> F from two partial products, high part caught first
    always_comb
    begin
        if ((ph_reg >> (8 + FRAC_BITS)) != 64'd0)
            wide_mag = 64'h1_0000_0000;
        else
            wide_mag = (ph_reg << (24 - FRAC_BITS)) + (prod >> FRAC_BITS);
        wide_term = sat_mag(gain_i_reg[31] ^ acc_reg[47], wide_mag);
    end

    always_comb
    begin
        step_mag = prod >> 16;
        step_s   = e_diff[32] ? -$signed(step_mag) : $signed(step_mag);
    end

    always_comb
    begin
        if (drive_reg > dmax_reg)
        begin
            drive_fin = dmax_reg;
            dclamp    = 1'b1;
        end
        else if (drive_reg < dmin_reg)
        begin
            drive_fin = dmin_reg;
            dclamp    = 1'b1;
        end
        else
        begin
            drive_fin = drive_reg;
            dclamp    = 1'b0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        acc_next         = acc_reg;
        df_next          = df_reg;
        drive_next       = drive_reg;
        iterm_next       = iterm_reg;
        raw_next         = raw_reg;
        ph_next          = ph_reg;
        rcp_next         = rcp_reg;
        iclamp_next      = iclamp_reg;
        div_neg_next     = div_neg_reg;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = prod;
        div_req.divisor  = US_PER_SEC;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = S_P1;
            end
            S_P1:
            begin
                mul_a       = abs32(gain_p_reg);
                mul_b       = abs32(err_reg);
                iclamp_next = 1'b0;
                state_next  = S_P2;
            end
            S_P2:
            begin
                drive_next = sat_mag(gain_p_reg[31] ^ err_reg[31], prod >> FRAC_BITS);
                state_next = goto_i ? S_I1 : (goto_d ? S_D1 : S_FIN);
            end
            S_I1:
            begin
                mul_a      = abs32(err_reg);
                mul_b      = d_reg;
                state_next = S_I2;
            end
            S_I2:
            begin
                ph_next    = prod;
                mul_a      = prod[31:0];
                mul_b      = US_RECIP[31:0];
                state_next = S_I3;
            end
            S_I3:
            begin
                rcp_next   = 66'(prod >> 32);
                mul_a      = ph_reg[31:0];
                mul_b      = US_RECIP[63:32];
                state_next = S_IR1;
            end
            S_IR1:
            begin
                rcp_next   = rcp_reg + 66'(prod);
                mul_a      = ph_reg[63:32];
                mul_b      = US_RECIP[31:0];
                state_next = S_IR2;
            end
            S_IR2:
            begin
                rcp_next   = rcp_reg + 66'(prod);
                mul_a      = ph_reg[63:32];
                mul_b      = US_RECIP[63:32];
                state_next = S_IR3;
            end
            S_IR3:
            begin
                acc_next   = sat48(49'(acc_reg) + inc_s);
                state_next = S_I4;
            end
            S_I4:
            begin
                mul_a      = abs32(gain_i_reg);
                mul_b      = 32'(acc_mag[47:24]);
                state_next = S_I5;
            end
            S_I5:
            begin
                ph_next    = prod;
                mul_a      = abs32(gain_i_reg);
                mul_b      = 32'(acc_mag[23:0]);
                state_next = S_I6;
            end
            S_I6:
            begin
                iterm_next       = wide_term;
                div_req.dividend = 64'(ilim_reg) << FRAC_BITS;
                div_req.divisor  = abs32(gain_i_reg);
                state_next       = S_I8;
                if (ilim_reg != 31'd0)
                begin
                    if (wide_term > lim_s)
                    begin
                        iterm_next    = lim_s;
                        iclamp_next   = 1'b1;
                        div_req.start = 1'b1;
                        div_neg_next  = gain_i_reg[31];
                        state_next    = S_I7;
                    end
                    else if (wide_term < -lim_s)
                    begin
                        iterm_next    = -lim_s;
                        iclamp_next   = 1'b1;
                        div_req.start = 1'b1;
                        div_neg_next  = ~gain_i_reg[31];
                        state_next    = S_I7;
                    end
                end
            end
            S_I7:
            begin
                if (div_done)
                begin
                    acc_next   = quo_s[47:0];
                    state_next = S_I8;
                end
            end
            S_I8:
            begin
                drive_next = sat32(64'(drive_reg) + 64'(iterm_reg));
                state_next = goto_d ? S_D1 : S_FIN;
            end
            S_D1:
            begin
                mul_a      = abs33(err_diff);
                mul_b      = US_PER_SEC;
                state_next = S_D2;
            end
            S_D2:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = d_reg;
                div_neg_next    = err_diff[32];
                state_next      = S_D3;
            end
            S_D3:
            begin
                if (div_done)
                begin
                    raw_next   = sat_mag(div_neg_reg, quo);
                    state_next = S_D4;
                end
            end
            S_D4:
            begin
                mul_a      = abs33(e_diff);
                mul_b      = 32'(alpha_reg);
                state_next = S_D5;
            end
            S_D5:
            begin
                df_next    = sat32(64'(df_reg) + step_s);
                state_next = S_D6;
            end
            S_D6:
            begin
                mul_a      = abs32(gain_d_reg);
                mul_b      = abs32(df_reg);
                state_next = S_D7;
            end
            S_D7:
            begin
                drive_next = sat32(64'(drive_reg)
                    + 64'(sat_mag(gain_d_reg[31] ^ df_reg[31], prod >> FRAC_BITS)));
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            dmin_reg      <= S32_MIN;
            dmax_reg      <= S32_MAX;
            ilim_reg      <= '0;
            alpha_reg     <= 17'h10000;
            acc_reg       <= '0;
            last_err_reg  <= '0;
            df_reg        <= '0;
            last_time_reg <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            df_reg    <= df_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (in_valid && in_ready)
                last_time_reg <= in_data.time_us;
            if (state_reg == S_FIN && state_next == S_IDLE)
            begin
                last_err_reg  <= err_reg;
                first_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            if (cfg_we && cfg_index <= REG_ALPHA)
            begin
                case (cfg_index)
                    REG_GAIN_P:    gain_p_reg <= cfg_data;
                    REG_GAIN_I:    gain_i_reg <= cfg_data;
                    REG_GAIN_D:    gain_d_reg <= cfg_data;
                    REG_DRIVE_MIN: dmin_reg   <= cfg_data;
                    REG_DRIVE_MAX: dmax_reg   <= cfg_data;
                    REG_ITERM_LIM: ilim_reg   <= cfg_data[30:0];
                    REG_ALPHA:     alpha_reg  <= cfg_data[16:0];
                    default:       alpha_reg  <= alpha_reg;
                endcase
                acc_reg       <= '0;
                last_err_reg  <= '0;
                df_reg        <= '0;
                last_time_reg <= '0;
                first_reg     <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg   <= drive_next;
        iterm_reg   <= iterm_next;
        raw_reg     <= raw_next;
        ph_reg      <= ph_next;
        rcp_reg     <= rcp_next;
        iclamp_reg  <= iclamp_next;
        div_neg_reg <= div_neg_next;
        if (in_valid && in_ready)
        begin
            err_reg <= in_data.error_in;
            d_reg   <= first_reg ? 32'd0 : in_data.time_us - last_time_reg;
        end
        if (state_reg == S_FIN && state_next == S_IDLE)
        begin
            out_reg.drive_out     <= drive_fin;
            out_reg.iterm_clamped <= iclamp_reg;
            out_reg.drive_clamped <= dclamp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again straight after a beat");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_I7 || state_reg == S_D3))
        else $error("divider finished outside a wait state");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index <= REG_ALPHA) |=> (first_reg && acc_reg == 48'sd0))
        else $error("register write did not clear the state");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && state_next == S_IDLE) |=> out_valid)
        else $error("finished item not presented");
`endif

endmodule

[design/pawd_mul.sv]
// Shared 32x32 unsigned multiplier with a registered product.
module pawd_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);
    import pawd_pkg::*;

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

[design/pawd_div.sv]
// Restoring 64/32 unsigned divider, one quotient bit per cycle.
module pawd_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pawd_pkg::pawd_div_req_t req,
    output logic [63:0]             quotient,
    output logic                    done
);
    import pawd_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] dsr_reg;

    logic [32:0] shifted;
    logic [33:0] trial;
    logic        qbit;

    assign shifted = {rem_reg, quo_reg[63]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};
    assign qbit    = ~trial[33];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[62:0], qbit};
            rem_reg <= qbit ? trial[31:0] : shifted[31:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[verif/pid_antiwindup_filtered_deriv_tb.sv]
// Self-checking testbench for the PID controller with anti-windup and filtered derivative.
module pid_antiwindup_filtered_deriv_tb;
    import pawd_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam longint Q_ONE = 64'sd65536;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    pawd_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    pawd_out_t out_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    pid_antiwindup_filtered_deriv dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mirror of the controller registers and loop state
    logic signed [31:0] kp, ki, kd, lo_clamp, hi_clamp;
    logic [30:0] ilimit;
    logic [16:0] alpha;
    longint acc;
    logic signed [31:0] prev_err, deriv_state;
    logic [31:0] prev_time;
    logic first_sample;

    pawd_out_t expected_drive[$];
    int error_count = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int cfg_writes = 0;
    int iclamp_seen = 0;
    int dclamp_seen = 0;
    int cycle_count = 0;
    bit calm = 1'b0;
    int ready_hold = 0;
    logic [31:0] clock_us = '0;

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint clip48(input longint v);
        if (v > 64'sh7FFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000)
            return -64'sh8000_0000_0000;
        return v;
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint pa, pb;
        pa = a;
        pb = b;
        return clip32((pa * pb) / Q_ONE);
    endfunction

    function automatic void clear_loop();
        acc = 0;
        prev_err = '0;
        deriv_state = '0;
        prev_time = '0;
        first_sample = 1'b1;
    endfunction

    function automatic void pid_predict(input logic signed [31:0] err, input logic [31:0] now,
                                        output pawd_out_t r);
        logic [31:0] elapsed;
        longint dt, e, inc, lim, raw, stp, drv;
        logic signed [127:0] wa, wb, wide;
        logic signed [31:0] iterm;
        bit ic, dc;
        elapsed = now - prev_time;
        dt = first_sample ? 64'sd0 : longint'(elapsed);
        e = err;
        ic = 1'b0;
        dc = 1'b0;
        prev_time = now;
        drv = fx_mul(kp, err);
        if (ki != 0 && dt != 0)
        begin
            inc = (e * dt) / 64'sd1000000;
            acc = clip48(acc + inc);
            wa = ki;
            wb = acc;
            wide = (wa * wb) / 128'sd65536;
            if (wide > 128'sd2147483647)
                iterm = 32'sh7FFF_FFFF;
            else if (wide < -128'sd2147483648)
                iterm = 32'sh8000_0000;
            else
                iterm = wide[31:0];
            if (ilimit != 0)
            begin
                lim = longint'(ilimit);
                if (longint'(iterm) > lim)
                begin
                    iterm = lim[31:0];
                    acc = clip48((lim * Q_ONE) / longint'(ki));
                    ic = 1'b1;
                end
                else if (longint'(iterm) < -lim)
                begin
                    iterm = -lim[31:0];
                    acc = clip48((-lim * Q_ONE) / longint'(ki));
                    ic = 1'b1;
                end
            end
            drv = clip32(drv + longint'(iterm));
        end
        if (kd != 0 && dt != 0)
        begin
            raw = clip32(((e - longint'(prev_err)) * 64'sd1000000) / dt);
            stp = ((raw - longint'(deriv_state)) * longint'(alpha)) / Q_ONE;
            deriv_state = clip32(longint'(deriv_state) + stp);
            drv = clip32(drv + longint'(fx_mul(kd, deriv_state)));
        end
        prev_err = err;
        first_sample = 1'b0;
        if (drv > longint'(hi_clamp))
        begin
            drv = hi_clamp;
            dc = 1'b1;
        end
        else if (drv < longint'(lo_clamp))
        begin
            drv = lo_clamp;
            dc = 1'b1;
        end
        r.drive_out = drv[31:0];
        r.iterm_clamped = ic;
        r.drive_clamped = dc;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (expected_drive.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
            end
            else
            begin
                pawd_out_t x;
                x = expected_drive.pop_front();
                iclamp_seen += x.iterm_clamped;
                dclamp_seen += x.drive_clamped;
                if (x.drive_out !== out_data.drive_out)
                begin
                    error_count++;
                    $display("%0t: drive_out expected %h actual %h", $time,
                             x.drive_out, out_data.drive_out);
                end
                if (x.iterm_clamped !== out_data.iterm_clamped)
                begin
                    error_count++;
                    $display("%0t: iterm_clamped expected %b actual %b", $time,
                             x.iterm_clamped, out_data.iterm_clamped);
                end
                if (x.drive_clamped !== out_data.drive_clamped)
                begin
                    error_count++;
                    $display("%0t: drive_clamped expected %b actual %b", $time,
                             x.drive_clamped, out_data.drive_clamped);
                end
            end
        end
    end

    // receiver back-pressure in short bursts
    always @(posedge clk)
    begin
        if (!rst_n || calm)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            ready_hold = $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_drive.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_beat(input logic signed [31:0] err, input logic [31:0] now);
        pawd_out_t r;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{error_in: err, time_us: now};
        do
            @(posedge clk);
        while (!in_ready);
        pid_predict(err, now, r);
        expected_drive.push_back(r);
        beats_sent++;
    endtask

    // let the block drain before touching a register
    task automatic settle();
        in_valid <= 1'b0;
        wait (expected_drive.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    // one write beat, with cfg_we dropped again before anything else is driven
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_writes++;
        case (idx)
            REG_GAIN_P:    kp = val;
            REG_GAIN_I:    ki = val;
            REG_GAIN_D:    kd = val;
            REG_DRIVE_MIN: lo_clamp = val;
            REG_DRIVE_MAX: hi_clamp = val;
            REG_ITERM_LIM: ilimit = val[30:0];
            REG_ALPHA:     alpha = val[16:0];
            default:       return;
        endcase
        clear_loop();
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom;
            2:       return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
            default: return $urandom_range(0, 1) ? $urandom_range(0, 4 << 16)
                                                  : -$urandom_range(0, 4 << 16);
        endcase
    endfunction

    function automatic logic [31:0] pick_error();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
            1, 2, 3: return $urandom;
            default: return $urandom_range(0, 1) ? $urandom_range(0, 8 << 16)
                                                  : -$urandom_range(0, 8 << 16);
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return $urandom;
            2, 3:    return $urandom_range(1, 1000000);
            default: return $urandom_range(1, 20000);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_beat(S32_MAX, 32'd0);
        send_beat(S32_MIN, 32'd1000);
        send_beat(32'sd12345, 32'hFFFF_FFFF);
    endtask

    task automatic test_proportional_extremes();
        settle();
        cfg_write(REG_GAIN_P, S32_MIN);
        send_beat(S32_MIN, 32'd5);
        send_beat(S32_MAX, 32'd5);
        send_beat(32'sd0, 32'd5);
        settle();
        cfg_write(REG_GAIN_P, 32'sh0001_0000);
        send_beat(32'sh0001_8000, 32'h8000_0000);
        send_beat(-32'sh0001_8000, 32'h7FFF_FFFF);
    endtask

    task automatic test_integral_windup();
        settle();
        cfg_write(REG_GAIN_P, '0);
        cfg_write(REG_GAIN_I, 32'sh0002_0000);
        cfg_write(REG_ITERM_LIM, 32'h0005_0000);
        send_beat(32'sh0004_0000, 32'hFFFF_FF00);
        send_beat(32'sh0004_0000, 32'h0000_0100);      // timestamp wraps
        send_beat(32'sh0004_0000, 32'h0000_0100);      // no time elapsed
        send_beat(S32_MAX, 32'h3000_0000);
        send_beat(S32_MIN, 32'h6000_0000);
        settle();
        cfg_write(REG_GAIN_I, -32'sh0000_8000);
        send_beat(S32_MIN, 32'd0);
        send_beat(S32_MIN, 32'd4000000);
    endtask

    task automatic test_derivative_filter();
        settle();
        cfg_write(REG_GAIN_I, '0);
        cfg_write(REG_GAIN_D, 32'sh0000_4000);
        cfg_write(REG_ALPHA, 32'h0001_FFFF);           // overshooting filter
        send_beat(S32_MIN, 32'd10);
        send_beat(S32_MAX, 32'd11);
        send_beat(32'sd0, 32'd2011);
        settle();
        cfg_write(REG_ALPHA, 32'd0);
        send_beat(32'sh0001_0000, 32'd10);
        send_beat(32'sh0010_0000, 32'd20);
    endtask

    task automatic test_inverted_window();
        settle();
        cfg_write(REG_GAIN_D, '0);
        cfg_write(REG_GAIN_P, 32'sh0001_0000);
        cfg_write(REG_DRIVE_MIN, 32'sh0064_0000);
        cfg_write(REG_DRIVE_MAX, -32'sh0064_0000);
        send_beat(32'sh00C8_0000, 32'd1);
        send_beat(-32'sh00C8_0000, 32'd2);
        send_beat(32'sd0, 32'd3);
    endtask

    task automatic test_unused_index();
        settle();
        cfg_write(REG_DRIVE_MIN, S32_MIN);
        cfg_write(REG_DRIVE_MAX, S32_MAX);
        cfg_write(REG_GAIN_I, 32'sh0001_0000);
        send_beat(32'sh0002_0000, 32'd100);
        send_beat(32'sh0002_0000, 32'd600);
        settle();
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);          // state must survive
        send_beat(32'sh0002_0000, 32'd1100);
    endtask

    task automatic random_phase(input int n);
        logic [31:0] lo, hi;
        settle();
        cfg_write(REG_GAIN_P, pick_gain());
        cfg_write(REG_GAIN_I, pick_gain());
        cfg_write(REG_GAIN_D, pick_gain());
        case ($urandom_range(0, 3))
            0:       begin lo = S32_MIN; hi = S32_MAX; end
            1:       begin lo = $urandom; hi = $urandom; end
            default: begin lo = -$urandom_range(1, 200 << 16); hi = $urandom_range(1, 200 << 16); end
        endcase
        cfg_write(REG_DRIVE_MIN, lo);
        cfg_write(REG_DRIVE_MAX, hi);
        case ($urandom_range(0, 4))
            0:       cfg_write(REG_ITERM_LIM, '0);
            1:       cfg_write(REG_ITERM_LIM, 32'h7FFF_FFFF);
            2:       cfg_write(REG_ITERM_LIM, $urandom);
            default: cfg_write(REG_ITERM_LIM, $urandom_range(1, 20 << 16));
        endcase
        case ($urandom_range(0, 3))
            0:       cfg_write(REG_ALPHA, 32'd65536);
            1:       cfg_write(REG_ALPHA, $urandom_range(0, 1) ? 32'd0 : 32'h0001_FFFF);
            default: cfg_write(REG_ALPHA, $urandom);
        endcase
        if ($urandom_range(0, 1))
            clock_us = $urandom;
        repeat (n)
        begin
            clock_us += pick_step();
            send_beat(pick_error(), clock_us);
        end
    endtask

    task automatic test_random_traffic();
        repeat (10) random_phase(150);
        calm = 1'b1;
        random_phase(150);
    endtask

    initial
    begin
        kp = '0; ki = '0; kd = '0;
        lo_clamp = S32_MIN;
        hi_clamp = S32_MAX;
        ilimit = '0;
        alpha = 17'd65536;
        clear_loop();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_proportional_extremes();
        test_integral_windup();
        test_derivative_filter();
        test_inverted_window();
        test_unused_index();
        test_random_traffic();
        in_valid <= 1'b0;
        wait (expected_drive.size() == 0);
        repeat (250) @(posedge clk);
        $display("Sent %0d samples over %0d register writes; %0d results checked.",
                 beats_sent, cfg_writes, beats_checked);
        $display("Integral limit hit %0d times, output clamp hit %0d times.",
                 iclamp_seen, dclamp_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
design/pawd_pkg.sv
design/pawd_mul.sv
design/pawd_div.sv
design/pid_antiwindup_filtered_deriv.sv
verif/pid_antiwindup_filtered_deriv_tb.sv
